// ===== rtl/arpc_pkg.sv =====
// shared types and constants for the arp cache table
package arpc_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ACT_W = 2;
  localparam int ST_W  = 3;
  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  // request codes; the fourth code is unused and reads as a miss
  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP_IP  = 2'd0,
    ACT_LOOKUP_MAC = 2'd1,
    ACT_UPDATE     = 2'd2
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  // request token that walks the cell chain
  typedef struct packed {
    logic             valid;
    logic [ACT_W-1:0] action;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic             hit;
    logic [IP_W-1:0]  found_ip;
    logic [MAC_W-1:0] found_mac;
  } token_t;

endpackage

// ===== rtl/arpc_if.sv =====
// request and response channel interfaces for the arp cache table
interface arpc_req_if import arpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [IP_W-1:0]  ip_addr;
  logic [MAC_W-1:0] mac_addr;

  modport source (output valid, action, ip_addr, mac_addr, input ready);
  modport sink   (input valid, action, ip_addr, mac_addr, output ready);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IP_W-1:0]  ip_found;
  logic [MAC_W-1:0] mac_found;

  modport source (output valid, status, ip_found, mac_found, input ready);
  modport sink   (input valid, status, ip_found, mac_found, output ready);
endinterface

// ===== rtl/arp_cache_table.sv =====
// arp cache table top level: request chain of entry cells and response register
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    action, ip_addr, mac_addr
//  rsp      out  valid/ready    status, ip_found, mac_found
//
// a request token walks the cell chain one cell per cycle; the pending result
// register then captures its result, which is loaded into the response
// register once that register is free. one request is in the chain at a time.
// reset clears the fill count, the state, the response valid and the token valid
// bits; the entry registers hold no reset and are only read below the fill count.
// a stalled response is held in its register; the next request is accepted
// while it waits, and its result waits in the flush state until rsp drains.
module arp_cache_table import arpc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  arpc_req_if.sink  req,
  arpc_rsp_if.source rsp
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // token chain: tok[0] is the injected request, tok[TABLE_DEPTH] leaves the row
  token_t           tok [TABLE_DEPTH+1];
  token_t           tail;

  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;

  // result of the request that just left the chain
  logic [ST_W-1:0]  exit_status;
  logic [IP_W-1:0]  exit_ip;
  logic [MAC_W-1:0] exit_mac;
  logic             exit_insert;
  logic             exit_load;

  // pending result, waiting for the response register
  logic [ST_W-1:0]  res_status;
  logic [IP_W-1:0]  res_ip;
  logic [MAC_W-1:0] res_mac;

  // response register
  logic             out_valid;
  logic [ST_W-1:0]  out_status;
  logic [IP_W-1:0]  out_ip;
  logic [MAC_W-1:0] out_mac;
  logic             out_load;

  logic             req_fire;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;

  // inject a fresh token into the head of the chain
  always_comb begin
    tok[0].valid     = req_fire;
    tok[0].action    = req.action;
    tok[0].ip        = req.ip_addr;
    tok[0].mac       = req.mac_addr;
    tok[0].hit       = 1'b0;
    tok[0].found_ip  = '0;
    tok[0].found_mac = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    arpc_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign tail = tok[TABLE_DEPTH];

  // turn the finished token into a status
  always_comb begin
    exit_status = ST_MISS;
    exit_ip     = '0;
    exit_mac    = '0;
    exit_insert = 1'b0;
    unique case (tail.action)
      ACT_LOOKUP_IP, ACT_LOOKUP_MAC: begin
        if (tail.hit) begin
          exit_status = ST_HIT;
          exit_ip     = tail.found_ip;
          exit_mac    = tail.found_mac;
        end
      end
      ACT_UPDATE: begin
        if (tail.hit) begin
          exit_status = ST_UPDATED;
        end else if (count < CW'(TABLE_DEPTH)) begin
          // the cell at the fill count took the new entry
          exit_status = ST_INSERTED;
          exit_insert = 1'b1;
        end else begin
          exit_status = ST_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer: idle, token in flight, result waiting for the response register
  always_comb begin
    state_next = state;
    count_next = count;
    exit_load  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (tail.valid) begin
          exit_load  = 1'b1;
          state_next = S_FLUSH;
          if (exit_insert) begin
            count_next = count + CW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exit_load) begin
      res_status <= exit_status;
      res_ip     <= exit_ip;
      res_mac    <= exit_mac;
    end
    if (out_load) begin
      out_status <= res_status;
      out_ip     <= res_ip;
      out_mac    <= res_mac;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.ip_found  = out_ip;
  assign rsp.mac_found = out_mac;

endmodule

// ===== rtl/arpc_cell.sv =====
// one table entry: compares the passing request token, updates it and itself
module arpc_cell import arpc_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [CW-1:0] count,
  input  token_t        tok_in,
  output token_t        tok_out
);

  localparam logic [CW-1:0] MY_SLOT = CW'(IDX);

  logic [IP_W-1:0]  entry_ip;
  logic [MAC_W-1:0] entry_mac;
  logic             live;
  logic             ip_match;
  logic             mac_match;
  logic             wr_mac;
  logic             wr_ip;
  token_t           tok_next;

  assign live      = tok_in.valid && (MY_SLOT < count);
  assign ip_match  = live && (entry_ip == tok_in.ip);
  assign mac_match = live && (entry_mac == tok_in.mac);

  always_comb begin
    tok_next = tok_in;
    wr_mac   = 1'b0;
    wr_ip    = 1'b0;
    unique case (tok_in.action)
      ACT_LOOKUP_IP: begin
        if (ip_match) begin
          tok_next.hit       = 1'b1;
          tok_next.found_ip  = entry_ip;
          tok_next.found_mac = entry_mac;
        end
      end
      ACT_LOOKUP_MAC: begin
        // later slots overwrite, so the newest entry wins
        if (mac_match) begin
          tok_next.hit       = 1'b1;
          tok_next.found_ip  = entry_ip;
          tok_next.found_mac = entry_mac;
        end
      end
      ACT_UPDATE: begin
        if (ip_match) begin
          tok_next.hit = 1'b1;
          wr_mac       = 1'b1;
        end else if (tok_in.valid && (MY_SLOT == count) && !tok_in.hit) begin
          // first free slot, and no earlier slot held this ip
          wr_ip  = 1'b1;
          wr_mac = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_ip) begin
      entry_ip <= tok_in.ip;
    end
    if (wr_mac) begin
      entry_mac <= tok_in.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.action    <= tok_next.action;
    tok_out.ip        <= tok_next.ip;
    tok_out.mac       <= tok_next.mac;
    tok_out.hit       <= tok_next.hit;
    tok_out.found_ip  <= tok_next.found_ip;
    tok_out.found_mac <= tok_next.found_mac;
  end

endmodule

// ===== rtl/arpc_checker.sv =====
// port-level assertions for the arp cache table and their bind
module arpc_checker import arpc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [ST_W-1:0]  status,
  input logic [IP_W-1:0]  ip_found,
  input logic [MAC_W-1:0] mac_found
);

  // a stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(ip_found)
      && $stable(mac_found))
    else $error("response changed while stalled");

  // one request at a time in the chain
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in flight");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= ST_FULL)
    else $error("undefined status code");

  // addresses come back only with a hit
  a_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_HIT |-> ip_found == '0 && mac_found == '0)
    else $error("address data on a non-hit response");

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .ip_found  (rsp.ip_found),
  .mac_found (rsp.mac_found)
);
